@@ src/dtcs_pkg.sv @@
// ----------------------------------------------------------------------------
// dtcs_pkg
// Shared types and constants for the direct torque control step block.
// ----------------------------------------------------------------------------
package dtcs_pkg;

    // fixed field widths
    localparam int TORQUE_W   = 44;
    localparam int OUT_FLUX_W = 32;
    localparam int BOUND_W    = 31;
    localparam int BOUND_SQ_W = 2 * BOUND_W;
    localparam int CFG_W      = 44;
    localparam int CFG_IDX_W  = 3;
    localparam int VEC_W      = 3;

    // result item: state, sector, torque, alpha, beta, then zero pad to bytes
    localparam int OUT_USED_W = 2 * VEC_W + TORQUE_W + 2 * OUT_FLUX_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // sector boundary slope 1.73 as 443/256
    localparam int SECTOR_NUM   = 443;
    localparam int SECTOR_SHIFT = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_UPPER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_LOWER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUX_UPPER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUX_LOWER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_CW    = 3'd4;

    typedef logic [VEC_W-1:0]            t_vec;
    typedef logic signed [TORQUE_W-1:0]  t_torque;
    typedef logic [BOUND_SQ_W-1:0]       t_bound_sq;

    // inverter voltage vectors
    localparam t_vec VEC_ZERO_LO = 3'd0;
    localparam t_vec VEC_V1      = 3'd1;
    localparam t_vec VEC_V2      = 3'd2;
    localparam t_vec VEC_V3      = 3'd3;
    localparam t_vec VEC_V4      = 3'd4;
    localparam t_vec VEC_V5      = 3'd5;
    localparam t_vec VEC_V6      = 3'd6;
    localparam t_vec VEC_ZERO_HI = 3'd7;

    // register reset values (flux bounds kept squared)
    localparam t_torque   TORQUE_UPPER_RST  = 44'sd11000000;
    localparam t_torque   TORQUE_LOWER_RST  = 44'sd9000000;
    localparam t_bound_sq FLUX_UPPER_SQ_RST = 62'd100200100;
    localparam t_bound_sq FLUX_LOWER_SQ_RST = 62'd99800100;

    // hysteresis band decisions
    typedef struct packed {
        logic torque_high;
        logic torque_low;
        logic flux_high;
        logic flux_low;
    } t_band;

endpackage

@@ src/dtcs_flux_integ.sv @@
// ----------------------------------------------------------------------------
// dtcs_flux_integ
// Adds the bus-voltage-scaled step of the held inverter vector to the flux
// vector and saturates each component at the flux width.
// ----------------------------------------------------------------------------
module dtcs_flux_integ #(
    parameter int FLUX_WIDTH   = 32,
    parameter int SAMPLE_WIDTH = 10
) (
    input  dtcs_pkg::t_vec                i_vec,
    input  logic [SAMPLE_WIDTH-1:0]       i_bus_voltage,
    input  logic signed [FLUX_WIDTH-1:0]  i_flux_alpha,
    input  logic signed [FLUX_WIDTH-1:0]  i_flux_beta,
    output logic signed [FLUX_WIDTH-1:0]  o_flux_alpha,
    output logic signed [FLUX_WIDTH-1:0]  o_flux_beta
);
    import dtcs_pkg::*;

    localparam int STEP_W = SAMPLE_WIDTH + 3;
    localparam int SUM_W  =
        ((FLUX_WIDTH > SAMPLE_WIDTH + 2) ? FLUX_WIDTH : SAMPLE_WIDTH + 2) + 1;

    logic [SAMPLE_WIDTH+2:0]   vb7;
    logic signed [STEP_W-1:0]  vb_s;
    logic signed [STEP_W-1:0]  vb2_s;
    logic signed [STEP_W-1:0]  k_s;
    logic signed [STEP_W-1:0]  d_alpha;
    logic signed [STEP_W-1:0]  d_beta;
    logic signed [SUM_W-1:0]   sum_alpha;
    logic signed [SUM_W-1:0]   sum_beta;

    // step sizes: vb, 2vb and (7vb)/4
    assign vb7   = {i_bus_voltage, 3'b000} - {3'b000, i_bus_voltage};
    assign vb_s  = $signed({3'b000, i_bus_voltage});
    assign vb2_s = $signed({2'b00, i_bus_voltage, 1'b0});
    assign k_s   = $signed({2'b00, vb7[SAMPLE_WIDTH+2:2]});

    // per-vector flux step
    always_comb begin
        d_alpha = '0;
        d_beta  = '0;
        case (i_vec)
            VEC_V1: begin
                d_alpha = vb2_s;
            end
            VEC_V2: begin
                d_alpha = vb_s;
                d_beta  = k_s;
            end
            VEC_V3: begin
                d_alpha = -vb_s;
                d_beta  = k_s;
            end
            VEC_V4: begin
                d_alpha = -vb2_s;
            end
            VEC_V5: begin
                d_alpha = -vb_s;
                d_beta  = -k_s;
            end
            VEC_V6: begin
                d_alpha = vb_s;
                d_beta  = -k_s;
            end
            default: begin
                d_alpha = '0;
                d_beta  = '0;
            end
        endcase
    end

    assign sum_alpha = SUM_W'(i_flux_alpha) + SUM_W'(d_alpha);
    assign sum_beta  = SUM_W'(i_flux_beta) + SUM_W'(d_beta);

    // saturate to the flux width
    always_comb begin
        if ((&sum_alpha[SUM_W-1:FLUX_WIDTH-1]) || !(|sum_alpha[SUM_W-1:FLUX_WIDTH-1])) begin
            o_flux_alpha = sum_alpha[FLUX_WIDTH-1:0];
        end else if (sum_alpha[SUM_W-1]) begin
            o_flux_alpha = {1'b1, {(FLUX_WIDTH-1){1'b0}}};
        end else begin
            o_flux_alpha = {1'b0, {(FLUX_WIDTH-1){1'b1}}};
        end
        if ((&sum_beta[SUM_W-1:FLUX_WIDTH-1]) || !(|sum_beta[SUM_W-1:FLUX_WIDTH-1])) begin
            o_flux_beta = sum_beta[FLUX_WIDTH-1:0];
        end else if (sum_beta[SUM_W-1]) begin
            o_flux_beta = {1'b1, {(FLUX_WIDTH-1){1'b0}}};
        end else begin
            o_flux_beta = {1'b0, {(FLUX_WIDTH-1){1'b1}}};
        end
    end

endmodule

@@ src/dtcs_estimator.sv @@
// ----------------------------------------------------------------------------
// dtcs_estimator
// Current vector, saturated torque estimate, flux sector and the torque and
// flux hysteresis band decisions for one updated flux vector.
// ----------------------------------------------------------------------------
module dtcs_estimator #(
    parameter int FLUX_WIDTH   = 32,
    parameter int SAMPLE_WIDTH = 10
) (
    input  logic signed [FLUX_WIDTH-1:0]  i_flux_alpha,
    input  logic signed [FLUX_WIDTH-1:0]  i_flux_beta,
    input  logic [SAMPLE_WIDTH-1:0]       i_phase_v_current,
    input  logic [SAMPLE_WIDTH-1:0]       i_phase_w_current,
    input  dtcs_pkg::t_torque             i_torque_upper,
    input  dtcs_pkg::t_torque             i_torque_lower,
    input  dtcs_pkg::t_bound_sq           i_flux_upper_sq,
    input  dtcs_pkg::t_bound_sq           i_flux_lower_sq,
    output dtcs_pkg::t_torque             o_torque,
    output dtcs_pkg::t_vec                o_sector,
    output dtcs_pkg::t_band               o_band
);
    import dtcs_pkg::*;

    localparam int S    = SAMPLE_WIDTH;
    localparam int PR_W = FLUX_WIDTH + S + 2;
    localparam int TD_W = (FLUX_WIDTH + S + 3 > TORQUE_W + 1) ?
                          FLUX_WIDTH + S + 3 : TORQUE_W + 1;
    localparam int SEC_W = FLUX_WIDTH + 11;
    localparam int ABS_W = (FLUX_WIDTH > BOUND_W + 1) ? FLUX_WIDTH : BOUND_W + 1;

    logic signed [S:0]        i_diff;
    logic signed [S+2:0]      i_diff3;
    logic signed [S+1:0]      cur_alpha;
    logic [S:0]               i_sum;
    logic [S+3:0]             i_sum7;
    logic signed [S+1:0]      cur_beta;
    logic signed [PR_W-1:0]   prod_a;
    logic signed [PR_W-1:0]   prod_b;
    logic signed [TD_W-1:0]   torque_full;
    logic signed [SEC_W-1:0]  sec_lhs;
    logic signed [SEC_W-1:0]  sec_den;
    logic signed [SEC_W-1:0]  sec_nden;
    logic                     alpha_pos;
    logic signed [ABS_W-1:0]  ext_a;
    logic signed [ABS_W-1:0]  ext_b;
    logic [ABS_W-1:0]         abs_a;
    logic [ABS_W-1:0]         abs_b;
    logic                     flux_big;
    logic [BOUND_SQ_W-1:0]    sq_a;
    logic [BOUND_SQ_W-1:0]    sq_b;
    logic [BOUND_SQ_W:0]      mag2;

    // current vector: floor(3(iw-iv)/2) and floor(7(iw+iv)/8)
    assign i_diff    = $signed({1'b0, i_phase_w_current}) - $signed({1'b0, i_phase_v_current});
    assign i_diff3   = ((S+3)'(i_diff) <<< 1) + (S+3)'(i_diff);
    assign cur_alpha = i_diff3[S+2:1];
    assign i_sum     = {1'b0, i_phase_w_current} + {1'b0, i_phase_v_current};
    assign i_sum7    = {i_sum, 3'b000} - {3'b000, i_sum};
    assign cur_beta  = $signed({1'b0, i_sum7[S+3:3]});

    // torque = alpha*cb - beta*ca, saturated to the torque width
    assign prod_a      = PR_W'(i_flux_alpha) * PR_W'(cur_beta);
    assign prod_b      = PR_W'(i_flux_beta) * PR_W'(cur_alpha);
    assign torque_full = TD_W'(prod_a) - TD_W'(prod_b);

    always_comb begin
        if ((&torque_full[TD_W-1:TORQUE_W-1]) || !(|torque_full[TD_W-1:TORQUE_W-1])) begin
            o_torque = torque_full[TORQUE_W-1:0];
        end else if (torque_full[TD_W-1]) begin
            o_torque = {1'b1, {(TORQUE_W-1){1'b0}}};
        end else begin
            o_torque = {1'b0, {(TORQUE_W-1){1'b1}}};
        end
    end

    // sector: 443*beta against +-256*alpha
    assign sec_lhs   = SEC_W'(i_flux_beta) * SEC_W'(SECTOR_NUM);
    assign sec_den   = SEC_W'(i_flux_alpha) <<< SECTOR_SHIFT;
    assign sec_nden  = -sec_den;
    assign alpha_pos = !i_flux_alpha[FLUX_WIDTH-1] && (|i_flux_alpha);

    always_comb begin
        if (alpha_pos) begin
            if (sec_lhs >= sec_den) begin
                o_sector = 3'd2;
            end else if (sec_lhs < sec_nden) begin
                o_sector = 3'd6;
            end else begin
                o_sector = 3'd1;
            end
        end else begin
            if (sec_lhs >= sec_nden) begin
                o_sector = 3'd3;
            end else if (sec_lhs < sec_den) begin
                o_sector = 3'd5;
            end else begin
                o_sector = 3'd4;
            end
        end
    end

    // flux magnitude as squared sum against squared bounds
    assign ext_a    = ABS_W'(i_flux_alpha);
    assign ext_b    = ABS_W'(i_flux_beta);
    assign abs_a    = ext_a[ABS_W-1] ? ABS_W'(-ext_a) : ext_a;
    assign abs_b    = ext_b[ABS_W-1] ? ABS_W'(-ext_b) : ext_b;
    assign flux_big = (|abs_a[ABS_W-1:BOUND_W]) || (|abs_b[ABS_W-1:BOUND_W]);
    assign sq_a     = BOUND_SQ_W'(abs_a[BOUND_W-1:0]) * BOUND_SQ_W'(abs_a[BOUND_W-1:0]);
    assign sq_b     = BOUND_SQ_W'(abs_b[BOUND_W-1:0]) * BOUND_SQ_W'(abs_b[BOUND_W-1:0]);
    assign mag2     = {1'b0, sq_a} + {1'b0, sq_b};

    // band decisions
    always_comb begin
        o_band.torque_high = (o_torque >= i_torque_upper);
        o_band.torque_low  = (o_torque < i_torque_lower);
        o_band.flux_high   = flux_big || (mag2 >= {1'b0, i_flux_upper_sq});
        o_band.flux_low    = !flux_big && (mag2 < {1'b0, i_flux_lower_sq});
    end

endmodule

@@ src/dtcs_switch_sel.sv @@
// ----------------------------------------------------------------------------
// dtcs_switch_sel
// Hysteresis switching table: picks the next inverter vector from the band
// decisions, the flux sector and the rotation direction.
// ----------------------------------------------------------------------------
module dtcs_switch_sel (
    input  dtcs_pkg::t_band  i_band,
    input  dtcs_pkg::t_vec   i_sector,
    input  dtcs_pkg::t_vec   i_prev_vec,
    input  logic             i_rotate_cw,
    output dtcs_pkg::t_vec   o_vec
);
    import dtcs_pkg::*;

    logic [3:0] sec4;
    logic [3:0] cand;
    logic [3:0] wrapped;
    logic       prev_active;

    assign sec4 = {1'b0, i_sector};

    // table lookup as sector offset, zero means zero request
    always_comb begin
        if (i_band.torque_high) begin
            if (i_band.flux_high) begin
                cand = i_rotate_cw ? sec4 + 4'd2 : sec4 + 4'd4;
            end else if (i_band.flux_low) begin
                cand = sec4;
            end else begin
                cand = 4'd0;
            end
        end else if (i_band.torque_low) begin
            if (i_band.flux_high) begin
                cand = i_rotate_cw ? sec4 + 4'd4 : sec4 + 4'd2;
            end else begin
                cand = i_rotate_cw ? sec4 + 4'd5 : sec4 + 4'd1;
            end
        end else begin
            cand = 4'd0;
        end
    end

    // wrap past vector six
    assign wrapped     = (cand > 4'd6) ? cand - 4'd6 : cand;
    assign prev_active = (i_prev_vec != VEC_ZERO_LO) && (i_prev_vec != VEC_ZERO_HI);

    // zero request picks the zero vector one switch away
    always_comb begin
        if (wrapped != 4'd0) begin
            o_vec = wrapped[VEC_W-1:0];
        end else if (prev_active) begin
            o_vec = i_prev_vec[0] ? VEC_ZERO_LO : VEC_ZERO_HI;
        end else begin
            o_vec = i_prev_vec;
        end
    end

endmodule

@@ src/direct_torque_control_step_top.sv @@
// Path: an input item passes through the input register, then one pass of logic
//   into the result register; the result register holds while the output stalls.
// Throughput: one item per cycle while the result channel is not stalled; the flux
//   and inverter vector feedback loop closes within that single pass of logic.
// Reset: synchronous active low; clears flux, inverter vector (vector 0),
//   valid flags and loads the threshold registers with their defaults.
// ----------------------------------------------------------------------------
// direct_torque_control_step_top
// Direct torque control step with hysteresis switching table, stream in/out.
// ----------------------------------------------------------------------------
module direct_torque_control_step_top #(
    parameter int FLUX_WIDTH   = 32,
    parameter int SAMPLE_WIDTH = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item channel
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // phase_v_current, phase_w_current, bus_voltage, zero pad
    input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // result item channel
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // inverter_state, flux_sector, torque_estimate, flux_alpha_out,
    // flux_beta_out, zero pad
    output logic [dtcs_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [dtcs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dtcs_pkg::CFG_W-1:0]          i_cfg_data
);
    import dtcs_pkg::*;

    localparam int S = SAMPLE_WIDTH;

    // configuration registers
    t_torque    r_torque_upper;
    t_torque    r_torque_lower;
    t_bound_sq  r_flux_upper_sq;
    t_bound_sq  r_flux_lower_sq;
    logic       r_rotate_cw;

    // input register
    logic          r_in_valid;
    logic [S-1:0]  r_phase_v;
    logic [S-1:0]  r_phase_w;
    logic [S-1:0]  r_bus_v;

    // controller state
    logic signed [FLUX_WIDTH-1:0]  r_flux_alpha;
    logic signed [FLUX_WIDTH-1:0]  r_flux_beta;
    t_vec                          r_vec;

    // result register
    logic                          r_out_valid;
    t_vec                          r_out_vec;
    t_vec                          r_out_sector;
    t_torque                       r_out_torque;
    logic [OUT_FLUX_W-1:0]         r_out_alpha;
    logic [OUT_FLUX_W-1:0]         r_out_beta;

    logic                          advance;
    logic signed [FLUX_WIDTH-1:0]  n_flux_alpha;
    logic signed [FLUX_WIDTH-1:0]  n_flux_beta;
    t_vec                          n_vec;
    t_vec                          sector;
    t_torque                       torque;
    t_band                         band;

    // handshake
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_out_beta, r_out_alpha, r_out_torque,
                                          r_out_sector, r_out_vec});

    // configuration writes; flux bounds are stored squared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_torque_upper  <= TORQUE_UPPER_RST;
            r_torque_lower  <= TORQUE_LOWER_RST;
            r_flux_upper_sq <= FLUX_UPPER_SQ_RST;
            r_flux_lower_sq <= FLUX_LOWER_SQ_RST;
            r_rotate_cw     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TORQUE_UPPER: begin
                    r_torque_upper <= i_cfg_data[TORQUE_W-1:0];
                end
                CFG_TORQUE_LOWER: begin
                    r_torque_lower <= i_cfg_data[TORQUE_W-1:0];
                end
                CFG_FLUX_UPPER: begin
                    r_flux_upper_sq <= BOUND_SQ_W'(i_cfg_data[BOUND_W-1:0])
                                     * BOUND_SQ_W'(i_cfg_data[BOUND_W-1:0]);
                end
                CFG_FLUX_LOWER: begin
                    r_flux_lower_sq <= BOUND_SQ_W'(i_cfg_data[BOUND_W-1:0])
                                     * BOUND_SQ_W'(i_cfg_data[BOUND_W-1:0]);
                end
                CFG_ROTATE_CW: begin
                    r_rotate_cw <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_phase_v <= i_s_axis_tdata[S-1:0];
            r_phase_w <= i_s_axis_tdata[2*S-1:S];
            r_bus_v   <= i_s_axis_tdata[3*S-1:2*S];
        end
    end

    // datapath
    dtcs_flux_integ #(
        .FLUX_WIDTH   (FLUX_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_flux_integ (
        .i_vec         (r_vec),
        .i_bus_voltage (r_bus_v),
        .i_flux_alpha  (r_flux_alpha),
        .i_flux_beta   (r_flux_beta),
        .o_flux_alpha  (n_flux_alpha),
        .o_flux_beta   (n_flux_beta)
    );

    dtcs_estimator #(
        .FLUX_WIDTH   (FLUX_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_estimator (
        .i_flux_alpha      (n_flux_alpha),
        .i_flux_beta       (n_flux_beta),
        .i_phase_v_current (r_phase_v),
        .i_phase_w_current (r_phase_w),
        .i_torque_upper    (r_torque_upper),
        .i_torque_lower    (r_torque_lower),
        .i_flux_upper_sq   (r_flux_upper_sq),
        .i_flux_lower_sq   (r_flux_lower_sq),
        .o_torque          (torque),
        .o_sector          (sector),
        .o_band            (band)
    );

    dtcs_switch_sel u_switch_sel (
        .i_band      (band),
        .i_sector    (sector),
        .i_prev_vec  (r_vec),
        .i_rotate_cw (r_rotate_cw),
        .o_vec       (n_vec)
    );

    // controller state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flux_alpha <= '0;
            r_flux_beta  <= '0;
            r_vec        <= VEC_ZERO_LO;
            r_out_valid  <= 1'b0;
        end else begin
            if (advance) begin
                r_flux_alpha <= n_flux_alpha;
                r_flux_beta  <= n_flux_beta;
                r_vec        <= n_vec;
                r_out_valid  <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_vec    <= n_vec;
            r_out_sector <= sector;
            r_out_torque <= torque;
            r_out_alpha  <= OUT_FLUX_W'(n_flux_alpha);
            r_out_beta   <= OUT_FLUX_W'(n_flux_beta);
        end
    end

    // checks
    a_advance_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_m_axis_tvalid)
        else $error("item processed without a result item");

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_out_sector != 3'd0) && (r_out_sector != 3'd7))
        else $error("flux sector out of range");

    a_zero_vec_holds_flux: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && ((r_vec == VEC_ZERO_LO) || (r_vec == VEC_ZERO_HI))
        |=> $stable(r_flux_alpha) && $stable(r_flux_beta))
        else $error("flux moved under a zero vector");

    a_zero_request_keeps_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !band.torque_high && !band.torque_low
        && ((r_vec == VEC_ZERO_LO) || (r_vec == VEC_ZERO_HI))
        |=> $stable(r_vec))
        else $error("zero request left a zero vector");

endmodule
